>>> hw/rtl/vhpd_pkg.sv
// Shared types and constants for the voxel hash point dedup unit.
// Holds payload structs, verdict codes, register indexes and FSM states.
// No dependencies.
package vhpd_pkg;

  typedef struct packed {
    logic               cloud_start;
    logic               coords_finite;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } vhpd_in_t;

  typedef struct packed {
    logic [2:0]         verdict;
    logic signed [31:0] kept_x;
    logic signed [31:0] kept_y;
    logic signed [31:0] kept_z;
    logic signed [63:0] cell_key;
    logic [12:0]        kept_total;
  } vhpd_out_t;

  // One table entry: the cloud epoch that wrote it and the stored key.
  typedef struct packed {
    logic [7:0]  epoch;
    logic [63:0] key;
  } vhpd_entry_t;

  localparam logic [2:0] VERDICT_KEPT       = 3'd0;
  localparam logic [2:0] VERDICT_NOT_FINITE = 3'd1;
  localparam logic [2:0] VERDICT_OUT_RANGE  = 3'd2;
  localparam logic [2:0] VERDICT_DUPLICATE  = 3'd3;
  localparam logic [2:0] VERDICT_LIMIT      = 3'd4;
  localparam logic [2:0] VERDICT_FULL       = 3'd5;

  localparam logic [1:0] CFG_VOXEL_SIZE  = 2'd0;
  localparam logic [1:0] CFG_RANGE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_POINT_LIMIT = 2'd2;

  localparam logic [30:0] DEFAULT_VOXEL = 31'd3277;
  localparam logic [31:0] PRIME_X       = 32'd73856093;
  localparam logic [31:0] PRIME_Y       = 32'd19349663;
  localparam logic [31:0] PRIME_Z       = 32'd83492791;
  localparam logic [12:0] COUNT_MAX     = 13'd8191;
  localparam logic [1:0]  AXIS_LIMIT    = 2'd3;
  localparam logic [1:0]  AXIS_Z        = 2'd2;
  localparam logic [7:0]  EPOCH_CLEAR   = 8'd0;
  localparam logic [7:0]  EPOCH_FIRST   = 8'd1;
  localparam logic [7:0]  EPOCH_LAST    = 8'hFF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_RANGE_MUL,
    ST_RANGE_ACC,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_KEY_MUL,
    ST_KEY_ACC,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_FINISH
  } vhpd_state_t;

endpackage

>>> hw/rtl/voxel_hash_point_dedup_unit.sv
// Top level of the voxel hash point dedup unit: sequencer, shared
// multiplier, bit-serial divider and the key table. Depends on vhpd_pkg.
//
// One point is taken at a time; in_stall stays high from the transfer of a
// point until its status is loaded into the output register. A point that
// is dropped early (closed cloud, not finite) goes from evaluation straight
// to finish; the range check adds a multiply and accumulate per axis and one
// for the limit; each of the three floor divisions runs a 32-step restoring
// divider, one quotient bit per cycle, then a key multiply and accumulate;
// each table probe is a registered memory read, then a compare, up to
// MAX_PROBES probes. Slot occupancy is tracked with an 8-bit cloud epoch
// stored beside each key: a new cloud bumps the epoch instead of clearing
// the table. After reset, and at every 255th cloud start when the epoch
// wraps, a clearing pass writes one entry per cycle over all TABLE_DEPTH
// slots while no point is accepted; configuration writes are taken at any
// time. TABLE_DEPTH must be a power of two; the block does not check it.
module voxel_hash_point_dedup_unit #(
  parameter int TABLE_DEPTH = 4096,
  parameter int MAX_PROBES  = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  vhpd_pkg::vhpd_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output vhpd_pkg::vhpd_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import vhpd_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PW    = $clog2(MAX_PROBES + 1);
  localparam logic [PW-1:0]    LAST_PROBE = PW'(MAX_PROBES - 1);
  localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(TABLE_DEPTH - 1);

  vhpd_state_t state, state_next;

  // Configuration registers
  logic [30:0] voxel_size;
  logic [30:0] range_limit;
  logic [12:0] point_limit;

  // Per-cloud state
  logic [12:0] kept_counter;
  logic        cloud_closed;
  logic [7:0]  epoch;

  // Working registers for the point in flight
  vhpd_in_t    item;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [63:0] key;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [1:0]  axis;
  logic [4:0]  bit_cnt;
  logic [PW-1:0]    probe;
  logic [IDX_W-1:0] clr_addr;
  logic        clr_resume;
  logic [2:0]  verdict;
  logic        kept;

  // Key table
  vhpd_entry_t mem [TABLE_DEPTH];
  vhpd_entry_t rd_data;
  logic        mem_we;
  logic [IDX_W-1:0] mem_waddr;
  vhpd_entry_t mem_wdata;

  logic signed [31:0] cur_coord;
  logic        cur_neg;
  logic [31:0] cur_mag;
  logic [31:0] cur_prime;
  logic [30:0] divisor;
  logic [31:0] div_shift;
  logic [32:0] div_diff;
  logic [31:0] mul_a, mul_b;
  logic [63:0] key_term;
  logic [31:0] key_fold;
  logic [IDX_W+PW-1:0] slot_sum;
  logic [IDX_W-1:0] slot;
  logic        entry_free, key_hit, out_free, accept;
  logic [12:0] count_inc;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Select the axis under work
  always_comb begin
    case (axis)
      2'd0: begin
        cur_coord = item.coord_x;
        cur_prime = PRIME_X;
      end
      2'd1: begin
        cur_coord = item.coord_y;
        cur_prime = PRIME_Y;
      end
      default: begin
        cur_coord = item.coord_z;
        cur_prime = PRIME_Z;
      end
    endcase
  end

  assign cur_neg = cur_coord[31];
  assign cur_mag = cur_neg ? (32'd0 - 32'(cur_coord)) : 32'(cur_coord);
  assign divisor = (voxel_size != 31'd0) ? voxel_size : DEFAULT_VOXEL;

  // One restoring step: remainder stays below the divisor, so bit 31 is zero
  assign div_shift = {rem[30:0], quo[31]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, divisor};

  // Shared multiplier operands
  always_comb begin
    mul_a = cur_mag;
    mul_b = cur_mag;
    case (state)
      ST_RANGE_MUL: begin
        if (axis == AXIS_LIMIT) begin
          mul_a = {1'b0, range_limit};
          mul_b = {1'b0, range_limit};
        end
      end
      ST_KEY_MUL: begin
        // Floor of a negative quotient: magnitude rounds up on a remainder
        mul_a = quo + {31'd0, (cur_neg && (rem != 32'd0))};
        mul_b = cur_prime;
      end
      default: begin
        mul_a = cur_mag;
        mul_b = cur_mag;
      end
    endcase
  end

  assign key_term = cur_neg ? (64'd0 - prod) : prod;
  assign key_fold = key[31:0] ^ key[63:32];
  assign slot_sum = {{PW{1'b0}}, key_fold[IDX_W-1:0]} + {{IDX_W{1'b0}}, probe};
  assign slot     = slot_sum[IDX_W-1:0];

  assign entry_free = (rd_data.epoch != epoch);
  assign key_hit    = (rd_data.key == key);
  assign count_inc  = (kept_counter == COUNT_MAX) ? kept_counter : kept_counter + 13'd1;

  // Table write: clearing pass or a new key
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = '{epoch: epoch, key: key};
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '{epoch: EPOCH_CLEAR, key: key};
    end else if (state == ST_PROBE_CHK && entry_free) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[slot];
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_SLOT) begin
          state_next = clr_resume ? ST_EVAL : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (in_data.cloud_start && epoch == EPOCH_LAST) ? ST_CLEAR : ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (cloud_closed || !item.coords_finite) begin
          state_next = ST_FINISH;
        end else if (range_limit != 31'd0) begin
          state_next = ST_RANGE_MUL;
        end else begin
          state_next = ST_DIV_LOAD;
        end
      end
      ST_RANGE_MUL: state_next = ST_RANGE_ACC;
      ST_RANGE_ACC: begin
        if (axis != AXIS_LIMIT) begin
          state_next = ST_RANGE_MUL;
        end else if (acc > prod) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: state_next = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (bit_cnt == 5'd31) begin
          state_next = ST_KEY_MUL;
        end
      end
      ST_KEY_MUL: state_next = ST_KEY_ACC;
      ST_KEY_ACC: state_next = (axis == AXIS_Z) ? ST_PROBE_RD : ST_DIV_LOAD;
      ST_PROBE_RD: state_next = ST_PROBE_CHK;
      ST_PROBE_CHK: begin
        if (entry_free || key_hit || probe == LAST_PROBE) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_PROBE_RD;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control state: configuration, cloud tracking, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_size   <= DEFAULT_VOXEL;
      range_limit  <= 31'd0;
      point_limit  <= 13'd0;
      kept_counter <= 13'd0;
      cloud_closed <= 1'b0;
      epoch        <= EPOCH_FIRST;
      clr_addr     <= '0;
      clr_resume   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VOXEL_SIZE:  voxel_size  <= cfg_data[30:0];
          CFG_RANGE_LIMIT: range_limit <= cfg_data[30:0];
          CFG_POINT_LIMIT: point_limit <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (accept && in_data.cloud_start) begin
        // New cloud: drop old slots by moving to a fresh epoch
        kept_counter <= 13'd0;
        cloud_closed <= 1'b0;
        if (epoch == EPOCH_LAST) begin
          epoch      <= EPOCH_FIRST;
          clr_addr   <= '0;
          clr_resume <= 1'b1;
        end else begin
          epoch <= epoch + 8'd1;
        end
      end
      if (state == ST_PROBE_CHK && entry_free) begin
        kept_counter <= count_inc;
        cloud_closed <= (point_limit != 13'd0) && (count_inc >= point_limit);
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          item    <= in_data;
          key     <= 64'd0;
          acc     <= 64'd0;
          axis    <= 2'd0;
          kept    <= 1'b0;
          verdict <= VERDICT_LIMIT;
        end
      end
      ST_EVAL: begin
        if (cloud_closed) begin
          verdict <= VERDICT_LIMIT;
        end else if (!item.coords_finite) begin
          verdict <= VERDICT_NOT_FINITE;
        end
      end
      ST_RANGE_ACC: begin
        if (axis != AXIS_LIMIT) begin
          acc  <= acc + prod;
          axis <= axis + 2'd1;
        end else begin
          axis    <= 2'd0;
          verdict <= VERDICT_OUT_RANGE;
        end
      end
      ST_DIV_LOAD: begin
        rem     <= 32'd0;
        quo     <= cur_mag;
        bit_cnt <= 5'd0;
      end
      ST_DIV_STEP: begin
        bit_cnt <= bit_cnt + 5'd1;
        if (!div_diff[32]) begin
          rem <= div_diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= div_shift;
          quo <= {quo[30:0], 1'b0};
        end
      end
      ST_KEY_ACC: begin
        key   <= key ^ key_term;
        probe <= '0;
        if (axis != AXIS_Z) begin
          axis <= axis + 2'd1;
        end
      end
      ST_PROBE_CHK: begin
        probe <= probe + PW'(1);
        if (entry_free) begin
          verdict <= VERDICT_KEPT;
          kept    <= 1'b1;
        end else if (key_hit) begin
          verdict <= VERDICT_DUPLICATE;
        end else begin
          verdict <= VERDICT_FULL;
        end
      end
      default: ;
    endcase
  end

  // Output register: load once the previous transfer is gone
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_data.verdict    <= verdict;
      out_data.kept_x     <= kept ? item.coord_x : 32'sd0;
      out_data.kept_y     <= kept ? item.coord_y : 32'sd0;
      out_data.kept_z     <= kept ? item.coord_z : 32'sd0;
      out_data.cell_key   <= key;
      out_data.kept_total <= kept_counter;
    end
  end

endmodule

>>> hw/rtl/vhpd_checker.sv
// Port-level checks for the voxel hash point dedup unit, bound to its top.
// Depends on vhpd_pkg and voxel_hash_point_dedup_unit.
module vhpd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input vhpd_pkg::vhpd_out_t out_data
);
  import vhpd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One point at a time: a transfer makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a point is in flight");

  // Drop the echo on every status but kept
  a_echo: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.verdict != VERDICT_KEPT |->
      out_data.kept_x == 0 && out_data.kept_y == 0 && out_data.kept_z == 0)
    else $error("echo present on dropped point");

  // Early drops never carry a key
  a_no_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.verdict == VERDICT_NOT_FINITE ||
                  out_data.verdict == VERDICT_OUT_RANGE ||
                  out_data.verdict == VERDICT_LIMIT) |-> out_data.cell_key == 0)
    else $error("key on early drop");

endmodule

bind voxel_hash_point_dedup_unit vhpd_checker u_vhpd_checker (.*);

>>> tb/voxel_hash_point_dedup_unit_test.sv
// Self-checking testbench for the voxel hash point dedup unit.
// Holds a scoreboard class that predicts each point's status, and the test top.
// Depends on vhpd_pkg and voxel_hash_point_dedup_unit.
`timescale 1ns / 100ps

class dedup_scoreboard;
  localparam int DEPTH  = 4096;
  localparam int PROBES = 8;

  bit [63:0] key_mem [DEPTH];
  bit        occupied [DEPTH];
  int unsigned kept_count;
  bit        closed;
  bit [30:0] voxel;
  bit [30:0] range_max;
  bit [12:0] keep_cap;

  vhpd_pkg::vhpd_out_t status_q [$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned verdict_seen [8];

  function new();
    kept_count = 0;
    closed = 0;
    voxel = vhpd_pkg::DEFAULT_VOXEL;
    range_max = '0;
    keep_cap = '0;
    mismatches = 0;
    checked = 0;
    foreach (occupied[i]) occupied[i] = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      vhpd_pkg::CFG_VOXEL_SIZE:  voxel = value[30:0];
      vhpd_pkg::CFG_RANGE_LIMIT: range_max = value[30:0];
      vhpd_pkg::CFG_POINT_LIMIT: keep_cap = value[12:0];
      default: ;
    endcase
  endfunction

  static function longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if (num % den < 0) q = q - 1;
    return q;
  endfunction

  static function bit [63:0] voxel_key(longint x, longint y, longint z, longint d);
    bit [63:0] ix, iy, iz;
    ix = floor_quot(x, d);
    iy = floor_quot(y, d);
    iz = floor_quot(z, d);
    return (ix * 64'(vhpd_pkg::PRIME_X)) ^ (iy * 64'(vhpd_pkg::PRIME_Y)) ^
           (iz * 64'(vhpd_pkg::PRIME_Z));
  endfunction

  static function int home_slot(bit [63:0] key);
    bit [63:0] h;
    h = key ^ (key >> 32);
    return int'(h[11:0]);
  endfunction

  static function longint unsigned sq_mag(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    return m * m;
  endfunction

  // Work out the status of one accepted point and queue it.
  function void note_point(vhpd_pkg::vhpd_in_t p);
    vhpd_pkg::vhpd_out_t r;
    longint x, y, z, d;
    longint unsigned dist2, lim2;
    bit [63:0] key;
    int home, s;
    bit kept;
    r = '0;
    kept = 0;
    x = p.coord_x;
    y = p.coord_y;
    z = p.coord_z;
    if (p.cloud_start) begin
      foreach (occupied[i]) occupied[i] = 0;
      kept_count = 0;
      closed = 0;
    end
    dist2 = sq_mag(x) + sq_mag(y) + sq_mag(z);
    lim2 = longint'(range_max) * longint'(range_max);
    if (closed) begin
      r.verdict = vhpd_pkg::VERDICT_LIMIT;
    end else if (!p.coords_finite) begin
      r.verdict = vhpd_pkg::VERDICT_NOT_FINITE;
    end else if (range_max != 0 && dist2 > lim2) begin
      r.verdict = vhpd_pkg::VERDICT_OUT_RANGE;
    end else begin
      d = (voxel != 0) ? longint'(voxel) : longint'(vhpd_pkg::DEFAULT_VOXEL);
      key = voxel_key(x, y, z, d);
      home = home_slot(key);
      r.cell_key = key;
      r.verdict = vhpd_pkg::VERDICT_FULL;
      for (int i = 0; i < PROBES; i++) begin
        s = (home + i) % DEPTH;
        if (!occupied[s]) begin
          occupied[s] = 1;
          key_mem[s] = key;
          r.verdict = vhpd_pkg::VERDICT_KEPT;
          kept = 1;
          break;
        end
        if (key_mem[s] == key) begin
          r.verdict = vhpd_pkg::VERDICT_DUPLICATE;
          break;
        end
      end
      if (kept) begin
        if (kept_count < vhpd_pkg::COUNT_MAX) kept_count++;
        if (keep_cap != 0 && kept_count >= keep_cap) closed = 1;
        r.kept_x = p.coord_x;
        r.kept_y = p.coord_y;
        r.kept_z = p.coord_z;
      end
    end
    r.kept_total = kept_count[12:0];
    status_q = {status_q, r};
  endfunction

  // Compare one delivered status with the oldest prediction.
  function void check_status(vhpd_pkg::vhpd_out_t got);
    vhpd_pkg::vhpd_out_t want;
    if (status_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected status: verdict %0d key %h", got.verdict, got.cell_key);
      return;
    end
    want = status_q.pop_front();
    checked++;
    verdict_seen[want.verdict]++;
    if (got.verdict !== want.verdict || got.kept_x !== want.kept_x ||
        got.kept_y !== want.kept_y || got.kept_z !== want.kept_z ||
        got.cell_key !== want.cell_key || got.kept_total !== want.kept_total) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch #%0d: exp v=%0d x=%h y=%h z=%h key=%h n=%0d",
                 mismatches, want.verdict, want.kept_x, want.kept_y, want.kept_z,
                 want.cell_key, want.kept_total);
        $display("             got v=%0d x=%h y=%h z=%h key=%h n=%0d",
                 got.verdict, got.kept_x, got.kept_y, got.kept_z,
                 got.cell_key, got.kept_total);
      end
    end
  endfunction

  function int pending();
    return status_q.size();
  endfunction
endclass

module voxel_hash_point_dedup_unit_test;
  import vhpd_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  vhpd_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  vhpd_out_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  dedup_scoreboard sb;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned sent;
  int unsigned stall_left;
  bit          stalling;

  voxel_hash_point_dedup_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** voxel_hash_point_dedup_unit: FAILED **");
      $finish;
    end
  end

  // Receiver: random runs of acceptance or stall, each of random length.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left == 0) begin
      stalling = ($urandom_range(0, 1) == 0);
      stall_left = stalling ? $urandom_range(1, 40) : $urandom_range(1, 300);
      out_stall <= stalling;
    end else begin
      stall_left--;
      out_stall <= stalling;
    end
  end

  // Check every status transfer at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_status(out_data);
  end

  // Transfer one point; the sender works in bursts with idle gaps between.
  task automatic send_point(input logic start, input logic finite,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    vhpd_in_t p;
    p.cloud_start = start;
    p.coords_finite = finite;
    p.coord_x = x;
    p.coord_y = y;
    p.coord_z = z;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 40)) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= p;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_point(p);
    sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Hold until every predicted status has been delivered.
  task automatic drain();
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Write one register; call only while the block is drained.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_points();
    int hits [$];
    int target;
    // Extremes of the coordinate range with the default voxel.
    send_point(1'b1, 1'b1, 32'h7FFFFFFF, 32'h80000000, 32'h00000000);
    send_point(1'b0, 1'b1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_point(1'b0, 1'b1, 32'h7FFFFFFF, 32'h80000000, 32'h00000001);  // same voxel
    send_point(1'b0, 1'b0, 32'h12345678, 32'h0, 32'h0);                // not finite
    send_point(1'b0, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    drain();
    // Range check: one metre.
    write_reg(CFG_RANGE_LIMIT, 32'h00010000);
    send_point(1'b1, 1'b1, 32'h00010000, 32'h0, 32'h0);   // exactly on the limit
    send_point(1'b0, 1'b1, 32'h00010000, 32'h1, 32'h0);   // just beyond
    send_point(1'b0, 1'b0, 32'h7FFFFFFF, 32'h0, 32'h0);   // not finite wins
    drain();
    // Point limit: the limiting point is kept, then the cloud closes.
    write_reg(CFG_RANGE_LIMIT, 32'h0);
    write_reg(CFG_POINT_LIMIT, 32'd2);
    send_point(1'b1, 1'b1, 32'h0, 32'h0, 32'h0);
    send_point(1'b0, 1'b1, 32'h00100000, 32'h0, 32'h0);
    send_point(1'b0, 1'b1, 32'h00200000, 32'h0, 32'h0);
    send_point(1'b0, 1'b0, 32'h0, 32'h0, 32'h0);          // closed beats not finite
    drain();
    // Table full: nine voxels on one home slot, unit voxel size.
    write_reg(CFG_POINT_LIMIT, 32'd0);
    write_reg(CFG_VOXEL_SIZE, 32'd1);
    target = sb.home_slot(sb.voxel_key(0, 0, 1, 1));
    for (int iz = 1; iz < 2000000 && hits.size() < 9; iz++)
      if (sb.home_slot(sb.voxel_key(0, 0, iz, 1)) == target)
        hits = {hits, iz};
    foreach (hits[i]) send_point(i == 0, 1'b1, 32'h0, 32'h0, hits[i]);
    send_point(1'b0, 1'b1, 32'h0, 32'h0, hits[0]);        // still a duplicate
    drain();
  endtask

  // One phase of random clouds under one register setting.
  task automatic random_phase(input int n_items);
    longint d, span, bx, by, bz;
    logic [31:0] px, py, pz;
    int left;
    int mode;
    left = 0;
    d = (sb.voxel != 0) ? longint'(sb.voxel) : longint'(DEFAULT_VOXEL);
    span = d * 4;
    if (span > 64'd1048576) span = 1048576;
    px = 0; py = 0; pz = 0;
    bx = 0; by = 0; bz = 0;
    for (int n = 0; n < n_items; n++) begin
      logic start;
      start = 0;
      if (left == 0) begin
        left = $urandom_range(1, 60);
        start = 1;
        bx = $signed(32'($urandom_range(0, 32'h00FFFFFF))) - 32'sh00800000;
        by = $signed(32'($urandom_range(0, 32'h00FFFFFF))) - 32'sh00800000;
        bz = $signed(32'($urandom_range(0, 32'h00FFFFFF))) - 32'sh00800000;
      end
      left--;
      if ($urandom_range(0, 99) < 2) start = 1;  // stray cloud start
      mode = $urandom_range(0, 99);
      if (mode < 65) begin
        px = 32'(bx + longint'($urandom_range(0, 32'(span))));
        py = 32'(by + longint'($urandom_range(0, 32'(span))));
        pz = 32'(bz + longint'($urandom_range(0, 32'(span))));
      end else if (mode < 85) begin
        px = $urandom; py = $urandom; pz = $urandom;
      end
      // otherwise repeat the previous point exactly
      send_point(start, $urandom_range(0, 99) < 95, px, py, pz);
      if (n == n_items / 2 && $urandom_range(0, 1) == 0) drain();
    end
    drain();
  endtask

  initial begin
    logic [31:0] vox_pick [6];
    logic [31:0] rng_pick [5];
    logic [31:0] cap_pick [5];
    sb = new();
    burst_left = 0;
    sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_VOXEL_SIZE;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_points();

    for (int ph = 0; ph < 7; ph++) begin
      vox_pick = '{32'd0, 32'd1, 32'd3277, 32'd65536, $urandom, 32'h7FFFFFFF};
      rng_pick = '{32'd0, 32'h7FFFFFFF, $urandom, 32'(($urandom_range(1, 64)) << 16), 32'd0};
      cap_pick = '{32'd0, 32'd1, 32'($urandom_range(2, 40)), 32'd4096, $urandom};
      write_reg(CFG_VOXEL_SIZE, (ph == 0) ? 32'd0 :
                (ph == 6) ? 32'h7FFFFFFF : vox_pick[$urandom_range(0, 5)]);
      write_reg(CFG_RANGE_LIMIT, (ph == 1) ? 32'h7FFFFFFF : rng_pick[$urandom_range(0, 4)]);
      write_reg(CFG_POINT_LIMIT, (ph == 2) ? 32'd4096 :
                (ph == 3) ? 32'd1 : cap_pick[$urandom_range(0, 4)]);
      random_phase(200);
    end

    drain();
    repeat (300) @(posedge clk);
    $display("covered %0d points over 7 random settings: kept %0d dup %0d full %0d",
             sent, sb.verdict_seen[VERDICT_KEPT], sb.verdict_seen[VERDICT_DUPLICATE],
             sb.verdict_seen[VERDICT_FULL]);
    $display("dropped: not finite %0d, out of range %0d, limit %0d; mismatches %0d",
             sb.verdict_seen[VERDICT_NOT_FINITE], sb.verdict_seen[VERDICT_OUT_RANGE],
             sb.verdict_seen[VERDICT_LIMIT], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** voxel_hash_point_dedup_unit: PASSED **");
    end else begin
      $display("** voxel_hash_point_dedup_unit: FAILED **");
    end
    $finish;
  end
endmodule
